[rtl/tga_pkg.sv]
`default_nettype none
package tga_pkg;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PIXELS = 2'd1,
    PH_IDLE   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER   = 2'd0,
    KIND_PIXEL    = 2'd1,
    KIND_MISMATCH = 2'd2,
    KIND_BAD_DEPTH = 2'd3
  } kind_t;

  localparam int unsigned HdrLen      = 18;
  localparam int unsigned TmplLen     = 12;
  localparam logic [4:0]  PosWidthLo  = 5'd12;
  localparam logic [4:0]  PosWidthHi  = 5'd13;
  localparam logic [4:0]  PosHeightLo = 5'd14;
  localparam logic [4:0]  PosHeightHi = 5'd15;
  localparam logic [4:0]  PosDepth    = 5'd16;
  localparam logic [4:0]  PosLast     = 5'(HdrLen - 1);
  localparam logic [4:0]  PosType     = 5'd2;
  localparam logic [7:0]  TypeTrue    = 8'd2;
  localparam logic [4:0]  Bpp3        = 5'd3;
  localparam logic [4:0]  Bpp4        = 5'd4;
  localparam logic [7:0]  AlphaOpaque = 8'hFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } tga_req_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        last_pixel;
  } tga_res_t;

  typedef struct packed {
    logic     fire;
    tga_res_t data;
  } tga_push_t;

  // Expected value of a fixed header byte: image type at one place, zero elsewhere.
  function automatic logic [7:0] tmpl_byte(input logic [4:0] pos);
    tmpl_byte = (pos == PosType) ? TypeTrue : 8'd0;
  endfunction

endpackage
`default_nettype wire

[rtl/tga_truecolor_stream_decoder.sv]
`default_nettype none
// Uncompressed true-color TGA stream decoder.
// Request channel (req_valid/req_ready/req_data): one file byte per request;
// start_of_file restarts the parser so that byte is header byte 0.
// Result channel (res_valid/res_ready/res_data): one header report, one error
// report (template mismatch, unsupported depth), or one RGBA pixel per result.
// Header bytes but the last, and the first bytes of each pixel, give no result.
// A result is registered in the output register, or in the skid slot if stalled.
// Throughput: one byte per cycle while req_ready is high; the parser state
// updates once per byte taken and the result lands in an output register.
// Stall: a two-entry output buffer (output register plus skid slot) lets one
// more request in while a result waits; req_ready drops only when both hold.
// After an error or the last pixel, bytes are taken and dropped until the
// next start_of_file.
// Reset: synchronous; the parser returns to the header phase with all counts
// cleared and both output slots empty. Bytes before any start_of_file are
// parsed as a file.
module tga_truecolor_stream_decoder (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire                logic req_valid,
  output logic                     req_ready,
  input  wire tga_pkg::tga_req_t req_data,
  output logic                     res_valid,
  input  wire                logic res_ready,
  output tga_pkg::tga_res_t        res_data
);
  import tga_pkg::*;

  logic      step;
  logic      full;
  tga_push_t push;

  assign req_ready = !full;
  assign step      = req_valid && req_ready;

  tga_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .req  (req_data),
    .push (push)
  );

  tga_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  a_full_implies_out: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> res_valid)
    else $error("skid slot holds a result while output register is empty");

  a_pixel_no_size: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_data.kind == KIND_PIXEL)) |->
    ((res_data.image_width == 16'd0) && (res_data.image_height == 16'd0)))
    else $error("pixel result carries header size");

  a_nonpixel_no_color: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_data.kind != KIND_PIXEL)) |->
    ((res_data.red == 8'd0) && (res_data.green == 8'd0) &&
     (res_data.blue == 8'd0) && (res_data.alpha == 8'd0)))
    else $error("non-pixel result carries color");

  a_error_no_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && ((res_data.kind == KIND_MISMATCH) ||
                   (res_data.kind == KIND_BAD_DEPTH))) |-> !res_data.last_pixel)
    else $error("error result marked as last pixel");

endmodule
`default_nettype wire

[rtl/tga_parse.sv]
`default_nettype none
module tga_parse (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire                logic step,
  input  wire tga_pkg::tga_req_t req,
  output tga_pkg::tga_push_t push
);
  import tga_pkg::*;

  phase_t      phase, phase_next, cur_phase;
  logic [4:0]  header_position, pos_next, cur_pos;
  logic        template_mismatch, mm_next, cur_mm;
  logic        four_byte_pixels, fb_next, cur_fb;
  logic        depth_bad, bad_next, cur_bad;
  logic [15:0] width_store, w_next, cur_w;
  logic [15:0] height_store, h_next, cur_h;
  logic [15:0] column_count, col_next, cur_col;
  logic [15:0] row_count, row_next, cur_row;
  logic [1:0]  pixel_byte_index, idx_next, cur_idx;
  logic [7:0]  held_blue, blue_next, cur_blue;
  logic [7:0]  held_green, green_next, cur_green;
  logic [7:0]  held_red, red_next, cur_red;
  logic [16:0] col_inc, row_inc;
  logic [4:0]  bpp;
  logic        last;
  logic [7:0]  byte_in;
  tga_push_t   res;

  assign byte_in = req.data_byte;
  assign bpp     = byte_in[7:3];

  // A start flag clears the whole parser before this byte is used.
  always_comb begin
    if (req.start_of_file) begin
      cur_phase = PH_HEADER;
      cur_pos   = '0;
      cur_mm    = 1'b0;
      cur_fb    = 1'b0;
      cur_bad   = 1'b0;
      cur_w     = '0;
      cur_h     = '0;
      cur_col   = '0;
      cur_row   = '0;
      cur_idx   = '0;
      cur_blue  = '0;
      cur_green = '0;
      cur_red   = '0;
    end else begin
      cur_phase = phase;
      cur_pos   = header_position;
      cur_mm    = template_mismatch;
      cur_fb    = four_byte_pixels;
      cur_bad   = depth_bad;
      cur_w     = width_store;
      cur_h     = height_store;
      cur_col   = column_count;
      cur_row   = row_count;
      cur_idx   = pixel_byte_index;
      cur_blue  = held_blue;
      cur_green = held_green;
      cur_red   = held_red;
    end
  end

  assign col_inc = {1'b0, cur_col} + 17'd1;
  assign row_inc = {1'b0, cur_row} + 17'd1;

  always_comb begin
    phase_next = cur_phase;
    pos_next   = cur_pos;
    mm_next    = cur_mm;
    fb_next    = cur_fb;
    bad_next   = cur_bad;
    w_next     = cur_w;
    h_next     = cur_h;
    col_next   = cur_col;
    row_next   = cur_row;
    idx_next   = cur_idx;
    blue_next  = cur_blue;
    green_next = cur_green;
    red_next   = cur_red;
    last       = 1'b0;
    res        = '0;

    unique case (cur_phase)
      PH_HEADER: begin
        priority if (cur_pos < 5'(TmplLen)) begin
          if (byte_in != tmpl_byte(cur_pos)) mm_next = 1'b1;
        end else if (cur_pos == PosWidthLo) begin
          w_next = {cur_w[15:8], byte_in};
        end else if (cur_pos == PosWidthHi) begin
          w_next = {byte_in, cur_w[7:0]};
        end else if (cur_pos == PosHeightLo) begin
          h_next = {cur_h[15:8], byte_in};
        end else if (cur_pos == PosHeightHi) begin
          h_next = {byte_in, cur_h[7:0]};
        end else if (cur_pos == PosDepth) begin
          fb_next  = (bpp == Bpp4);
          bad_next = !((bpp == Bpp3) || (bpp == Bpp4));
        end else begin
        end

        if (cur_pos != PosLast) begin
          pos_next = cur_pos + 5'd1;
        end else begin
          res.fire = 1'b1;
          priority if (cur_mm) begin
            phase_next    = PH_IDLE;
            res.data.kind = KIND_MISMATCH;
          end else if (cur_bad) begin
            phase_next    = PH_IDLE;
            res.data.kind = KIND_BAD_DEPTH;
          end else begin
            last                  = (cur_w == 16'd0) || (cur_h == 16'd0);
            phase_next            = last ? PH_IDLE : PH_PIXELS;
            col_next              = '0;
            row_next              = '0;
            idx_next              = '0;
            res.data.kind         = KIND_HEADER;
            res.data.image_width  = cur_w;
            res.data.image_height = cur_h;
            res.data.last_pixel   = last;
          end
        end
      end

      PH_PIXELS: begin
        unique case (cur_idx)
          2'd0: begin
            blue_next = byte_in;
            idx_next  = 2'd1;
          end
          2'd1: begin
            green_next = byte_in;
            idx_next   = 2'd2;
          end
          default: begin
            if (cur_idx == 2'd2) red_next = byte_in;
            if ((cur_idx == 2'd2) && cur_fb) begin
              idx_next = 2'd3;
            end else begin
              idx_next = 2'd0;
              last = (col_inc == {1'b0, cur_w}) && (row_inc == {1'b0, cur_h});
              if (col_inc >= {1'b0, cur_w}) begin
                col_next = '0;
                row_next = row_inc[15:0];
              end else begin
                col_next = col_inc[15:0];
              end
              if (last) phase_next = PH_IDLE;
              res.fire            = 1'b1;
              res.data.kind       = KIND_PIXEL;
              res.data.red        = red_next;
              res.data.green      = cur_green;
              res.data.blue       = cur_blue;
              res.data.alpha      = (cur_idx == 2'd2) ? AlphaOpaque : byte_in;
              res.data.last_pixel = last;
            end
          end
        endcase
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      header_position   <= '0;
      template_mismatch <= 1'b0;
      four_byte_pixels  <= 1'b0;
      depth_bad         <= 1'b0;
      width_store       <= '0;
      height_store      <= '0;
      column_count      <= '0;
      row_count         <= '0;
      pixel_byte_index  <= '0;
      held_blue         <= '0;
      held_green        <= '0;
      held_red          <= '0;
    end else if (step) begin
      phase             <= phase_next;
      header_position   <= pos_next;
      template_mismatch <= mm_next;
      four_byte_pixels  <= fb_next;
      depth_bad         <= bad_next;
      width_store       <= w_next;
      height_store      <= h_next;
      column_count      <= col_next;
      row_count         <= row_next;
      pixel_byte_index  <= idx_next;
      held_blue         <= blue_next;
      held_green        <= green_next;
      held_red          <= red_next;
    end
  end

  always_comb begin
    push      = res;
    push.fire = res.fire && step;
  end

endmodule
`default_nettype wire

[rtl/tga_skid.sv]
`default_nettype none
module tga_skid (
  input  wire                 logic clk,
  input  wire                 logic rst,
  input  wire tga_pkg::tga_push_t push,
  output logic                      full,
  output logic                      res_valid,
  input  wire                 logic res_ready,
  output tga_pkg::tga_res_t         res_data
);
  import tga_pkg::*;

  logic     out_valid;
  tga_res_t out_data;
  logic     sk_valid;
  tga_res_t sk_data;
  logic     pop;

  assign pop       = out_valid && res_ready;
  assign full      = sk_valid;
  assign res_valid = out_valid;
  assign res_data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (pop) begin
      if (sk_valid) begin
        out_valid <= 1'b1;
        sk_valid  <= 1'b0;
      end else begin
        out_valid <= push.fire;
      end
    end else if (push.fire) begin
      // Park the result in the skid slot while the output register is stalled.
      if (out_valid) sk_valid <= 1'b1;
      else           out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && sk_valid) begin
      out_data <= sk_data;
    end else if (push.fire && (pop || !out_valid)) begin
      out_data <= push.data;
    end
    if (push.fire && out_valid && !pop) sk_data <= push.data;
  end

endmodule
`default_nettype wire

[tb/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tga_pkg::*;

  localparam int ItemTarget = 1500;
  localparam int StallLimit = 1000;

  typedef struct packed {
    logic [7:0] b;
    logic       sof;
    logic       fixed;
    tga_res_t   res;
  } dir_row_t;

  // One small 32-bit image (1x1), then a byte past its end, then a restart.
  localparam dir_row_t DirRows [24] = '{
    '{8'h00, 1'b0, 1'b0, '0},  // first header byte arrives without a start flag
    '{8'h00, 1'b0, 1'b0, '0},
    '{TypeTrue, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h27, 1'b0, 1'b0, '0},  // 39 bits: four bytes per pixel
    '{8'hFF, 1'b0, 1'b1, '{KIND_HEADER, 8'h00, 8'h00, 8'h00, 8'h00, 16'd1, 16'd1, 1'b0}},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'h7F, 1'b0, 1'b1, '{KIND_PIXEL, 8'h80, 8'hFF, 8'h00, 8'h7F, 16'd0, 16'd0, 1'b1}},
    '{8'hAA, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b0, '0}
  };

  logic     clk = 1'b0;
  logic     rst;
  logic     req_valid;
  logic     req_ready;
  tga_req_t req_data;
  logic     res_valid;
  logic     res_ready;
  tga_res_t res_data;

  tga_res_t pending_results [$];
  tga_res_t want;
  int       errors = 0;
  int       file_bytes = 0;
  int       idle_cycles = 0;
  int       stall_left = 0;
  bit       quiet = 1'b0;

  // Decoder state mirrored by the testbench
  phase_t      dec_phase;
  logic [4:0]  dec_pos;
  bit          dec_tmpl_bad;
  bit          dec_four;
  bit          dec_depth_bad;
  logic [15:0] dec_w;
  logic [15:0] dec_h;
  logic [15:0] dec_col;
  logic [15:0] dec_row;
  logic [1:0]  dec_idx;
  logic [7:0]  dec_b;
  logic [7:0]  dec_g;
  logic [7:0]  dec_r;

  always #5 clk = ~clk;

  tga_truecolor_stream_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  task automatic clear_decoder();
    dec_phase = PH_HEADER;
    dec_pos = '0;
    dec_tmpl_bad = 1'b0;
    dec_four = 1'b0;
    dec_depth_bad = 1'b0;
    dec_w = '0;
    dec_h = '0;
    dec_col = '0;
    dec_row = '0;
    dec_idx = '0;
    dec_b = '0;
    dec_g = '0;
    dec_r = '0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic sof, output bit got,
                             output tga_res_t r);
    logic [4:0]  bpp;
    logic [16:0] col_next;
    got = 1'b0;
    r = '0;
    if (sof) clear_decoder();
    case (dec_phase)
      PH_HEADER: begin
        if (dec_pos < TmplLen) begin
          if (b != ((dec_pos == PosType) ? TypeTrue : 8'h00)) dec_tmpl_bad = 1'b1;
        end else begin
          case (dec_pos)
            PosWidthLo:  dec_w[7:0] = b;
            PosWidthHi:  dec_w[15:8] = b;
            PosHeightLo: dec_h[7:0] = b;
            PosHeightHi: dec_h[15:8] = b;
            PosDepth: begin
              bpp = b[7:3];
              dec_four = (bpp == Bpp4);
              dec_depth_bad = !(bpp == Bpp3 || bpp == Bpp4);
            end
            default: ;
          endcase
        end
        if (dec_pos != PosLast) begin
          dec_pos = dec_pos + 5'd1;
        end else begin
          got = 1'b1;
          // template mismatch wins over bad depth
          if (dec_tmpl_bad) begin
            r.kind = KIND_MISMATCH;
            dec_phase = PH_IDLE;
          end else if (dec_depth_bad) begin
            r.kind = KIND_BAD_DEPTH;
            dec_phase = PH_IDLE;
          end else begin
            r.kind = KIND_HEADER;
            r.image_width = dec_w;
            r.image_height = dec_h;
            r.last_pixel = (dec_w == 16'd0 || dec_h == 16'd0);
            dec_phase = r.last_pixel ? PH_IDLE : PH_PIXELS;
            dec_col = '0;
            dec_row = '0;
            dec_idx = '0;
          end
        end
      end
      PH_PIXELS: begin
        case (dec_idx)
          2'd0: dec_b = b;
          2'd1: dec_g = b;
          2'd2: dec_r = b;
          default: ;
        endcase
        if (dec_idx == 2'd3 || (dec_idx == 2'd2 && !dec_four)) begin
          got = 1'b1;
          r.kind = KIND_PIXEL;
          r.red = dec_r;
          r.green = dec_g;
          r.blue = dec_b;
          r.alpha = (dec_idx == 2'd3) ? b : AlphaOpaque;
          col_next = {1'b0, dec_col} + 17'd1;
          r.last_pixel = (col_next == {1'b0, dec_w}) &&
                         ({1'b0, dec_row} + 17'd1 == {1'b0, dec_h});
          if (col_next >= {1'b0, dec_w}) begin
            dec_col = '0;
            dec_row = dec_row + 16'd1;
          end else begin
            dec_col = col_next[15:0];
          end
          if (r.last_pixel) dec_phase = PH_IDLE;
          dec_idx = '0;
        end else begin
          dec_idx = dec_idx + 2'd1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b, input logic sof, input logic fixed,
                           input tga_res_t fixed_res);
    bit       got;
    tga_res_t r;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= '{data_byte: b, start_of_file: sof};
    do @(posedge clk); while (!req_ready);
    file_bytes++;
    decode_byte(b, sof, got, r);
    if (got || fixed) pending_results.push_back(fixed ? fixed_res : r);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 9))
      0: pick_size = 16'($urandom);
      1: pick_size = 16'hFFFF;
      2: pick_size = 16'h0000;
      default: pick_size = 16'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic send_file();
    logic [7:0]  hdr [18];
    logic [15:0] w;
    logic [15:0] h;
    int unsigned npix;
    int unsigned nbytes;
    int unsigned stop_at;
    int          i;
    w = pick_size();
    h = pick_size();
    for (i = 0; i < TmplLen; i++) hdr[i] = (i == PosType) ? TypeTrue : 8'h00;
    if ($urandom_range(0, 5) == 0) hdr[$urandom_range(0, 11)] = 8'($urandom_range(0, 255));
    hdr[12] = w[7:0];
    hdr[13] = w[15:8];
    hdr[14] = h[7:0];
    hdr[15] = h[15:8];
    case ($urandom_range(0, 6))
      0: hdr[16] = 8'($urandom_range(0, 255));
      1, 2, 3: hdr[16] = 8'($urandom_range(24, 31));
      default: hdr[16] = 8'($urandom_range(32, 39));
    endcase
    hdr[17] = 8'($urandom_range(0, 255));
    // cut some headers short; the next start flag restarts the parser
    stop_at = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 17) : 18;
    for (i = 0; i < stop_at; i++) push_byte(hdr[i], i == 0, 1'b0, '0);
    if (stop_at < 18) return;
    npix = w * h;
    if (npix > 20) npix = 20;
    nbytes = npix * ((hdr[16][7:3] == Bpp4) ? 4 : 3);
    if ($urandom_range(0, 7) == 0) nbytes = $urandom_range(0, nbytes);
    nbytes += $urandom_range(0, 3);
    for (i = 0; i < nbytes; i++) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
  endtask

  initial begin
    int pick;
    int n;
    rst = 1'b1;
    req_valid = 1'b0;
    req_data = '0;
    clear_decoder();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (DirRows[i]) push_byte(DirRows[i].b, DirRows[i].sof, DirRows[i].fixed,
                                   DirRows[i].res);
    // hold the sender until the result side has caught up
    wait_drained();
    while (file_bytes < ItemTarget) begin
      quiet = (file_bytes > ItemTarget - 200);
      pick = $urandom_range(0, 19);
      if (pick == 0 && !quiet) begin
        wait_drained();
      end else if (pick < 3) begin
        n = $urandom_range(1, 6);
        repeat (n) push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                             1'b0, '0);
      end else begin
        send_file();
      end
    end
    wait_drained();
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    res_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 3);
      res_ready <= (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d rgba %h %h %h %h size %0d x %0d last %b",
                 $time, res_data.kind, res_data.red, res_data.green, res_data.blue,
                 res_data.alpha, res_data.image_width, res_data.image_height,
                 res_data.last_pixel);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (res_data.kind !== want.kind || res_data.red !== want.red ||
            res_data.green !== want.green || res_data.blue !== want.blue ||
            res_data.alpha !== want.alpha || res_data.image_width !== want.image_width ||
            res_data.image_height !== want.image_height ||
            res_data.last_pixel !== want.last_pixel) begin
          $display({"%0t: result mismatch: expected kind %0d rgba %h %h %h %h size %0d x %0d",
                    " last %b, actual kind %0d rgba %h %h %h %h size %0d x %0d last %b"},
                   $time, want.kind, want.red, want.green, want.blue, want.alpha,
                   want.image_width, want.image_height, want.last_pixel,
                   res_data.kind, res_data.red, res_data.green, res_data.blue,
                   res_data.alpha, res_data.image_width, res_data.image_height,
                   res_data.last_pixel);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == StallLimit) begin
        $display("%0t: no request or result moved for %0d cycles", $time, StallLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
